@@ src/cfrp_pkg.sv @@
// Shared types and constants for the chunked file receive block.
// No dependencies; imported by every module under src.
package cfrp_pkg;

    localparam int CQ_DEPTH = 4;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRANSFER_LENGTH = 3'd0,
        CFG_SYNC_CODE       = 3'd1,
        CFG_ACK_CODE        = 3'd2,
        CFG_END_CODE        = 3'd3,
        CFG_CHECK_CODE      = 3'd4,
        CFG_SUM_MSB_FIRST   = 3'd5
    } cfg_idx_t;

    localparam logic [23:0] RST_TRANSFER_LENGTH = 24'd0;
    localparam logic [7:0]  RST_SYNC_CODE       = 8'd22;
    localparam logic [7:0]  RST_ACK_CODE        = 8'd6;
    localparam logic [7:0]  RST_END_CODE        = 8'd26;
    localparam logic [7:0]  RST_CHECK_CODE      = 8'd67;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BUSY    = 2'd1;
    localparam logic [1:0] ST_NO_END  = 2'd2;
    localparam logic [1:0] ST_BAD_SUM = 2'd3;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_ACK_DATA = 6'b000010,
        PH_DATA     = 6'b000100,
        PH_END      = 6'b001000,
        PH_ACK_SUM  = 6'b010000,
        PH_SUM      = 6'b100000
    } phase_t;

    // classified input item
    typedef struct packed {
        logic       start;
        logic       is_ack;
        logic       is_end;
        logic [7:0] rx_byte;
    } cmd_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        data_valid;
        logic [23:0] data_offset;
        logic [7:0]  data_byte;
        logic        done_res;
        logic [1:0]  status;
        logic        last;
    } res_t;

    // up to two results written per engine step
    typedef struct packed {
        logic [1:0] cnt;
        res_t       r0;
        res_t       r1;
    } res_push_t;

endpackage

@@ src/cfrp_cmdq.sv @@
// Front end: accepts input items, tags ack/end matches, queues them.
// Depends on cfrp_pkg.
module cfrp_cmdq
    import cfrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       mode,
    input  logic [7:0] rx_byte,
    input  logic [7:0] ack_code,
    input  logic [7:0] end_code,
    output logic       cmd_valid,
    output cmd_t       cmd,
    input  logic       cmd_pop
);

    cmd_t                mem_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wp_reg, wp_next;
    logic [CQ_PTR_W-1:0] rp_reg, rp_next;
    logic [CQ_PTR_W:0]   cnt_reg, cnt_next;
    logic                push_ok;
    logic                pop_ok;
    cmd_t                entry;

    assign full      = (cnt_reg == (CQ_PTR_W+1)'(CQ_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign push_ok   = push && !full;
    assign pop_ok    = cmd_pop && cmd_valid;
    assign cmd       = mem_reg[rp_reg];

    always_comb
    begin
        entry.start   = !mode;
        entry.is_ack  = (rx_byte == ack_code);
        entry.is_end  = (rx_byte == end_code);
        entry.rx_byte = rx_byte;
        wp_next  = push_ok ? wp_reg + 1'b1 : wp_reg;
        rp_next  = pop_ok ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (CQ_PTR_W+1)'(push_ok) - (CQ_PTR_W+1)'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wp_reg] <= entry;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (CQ_PTR_W+1)'(CQ_DEPTH))
        else $error("cmdq count overflow");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) || (cnt_reg == (CQ_PTR_W+1)'(CQ_DEPTH)) || (wp_reg != rp_reg))
        else $error("cmdq pointers disagree with count");

endmodule

@@ src/cfrp_engine.sv @@
// Back end: runs the transfer protocol, one queued item per step.
// Depends on cfrp_pkg; fed by cfrp_cmdq, writes into cfrp_resq.
module cfrp_engine
    import cfrp_pkg::*;
#(
    parameter int CHUNK_BYTES = 16,
    parameter int LENGTH_BITS = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  cmd_t                cmd,
    output logic                cmd_pop,
    input  logic [RQ_PTR_W:0]   res_free,
    output res_push_t           res_push,
    input  logic [23:0]         transfer_length,
    input  logic [7:0]          sync_code,
    input  logic [7:0]          check_code,
    input  logic                sum_msb_first
);

    localparam int CCW = $clog2(CHUNK_BYTES + 1);
    localparam int CW  = (LENGTH_BITS > 24) ? LENGTH_BITS : 24;

    phase_t                 phase_reg, phase_next;
    logic [CCW-1:0]         chunk_reg, chunk_next;
    logic [LENGTH_BITS-1:0] off_reg, off_next;
    logic [31:0]            run_reg, run_next;
    logic [31:0]            rsum_reg, rsum_next;
    logic [1:0]             scnt_reg, scnt_next;
    logic [CW-1:0]          len_now;
    logic [CW-1:0]          off_inc_ext;
    logic [LENGTH_BITS-1:0] off_inc;
    logic [CCW-1:0]         chunk_inc;
    logic [31:0]            rsum_upd;
    res_t                   r0, r1;
    logic [1:0]             n;

    assign len_now   = CW'(transfer_length) & CW'({LENGTH_BITS{1'b1}});
    assign off_inc   = off_reg + 1'b1;
    assign off_inc_ext = CW'(off_inc);
    assign chunk_inc = chunk_reg + 1'b1;
    assign rsum_upd  = sum_msb_first ? {rsum_reg[23:0], cmd.rx_byte}
                                     : (rsum_reg | (32'(cmd.rx_byte) << {scnt_reg, 3'b000}));
    assign cmd_pop   = cmd_valid && (res_free >= (RQ_PTR_W+1)'(2));

    always_comb
    begin
        phase_next = phase_reg;
        chunk_next = chunk_reg;
        off_next   = off_reg;
        run_next   = run_reg;
        rsum_next  = rsum_reg;
        scnt_next  = scnt_reg;
        r0 = '0;
        r1 = '0;
        n  = 2'd0;
        if (cmd.start)
        begin
            chunk_next = '0;
            off_next   = '0;
            run_next   = '0;
            rsum_next  = '0;
            scnt_next  = '0;
            if (len_now == '0)
            begin
                phase_next = PH_END;
            end
            else
            begin
                phase_next  = PH_ACK_DATA;
                r0.tx_valid = 1'b1;
                r0.tx_byte  = sync_code;
                r0.last     = 1'b1;
                n           = 2'd1;
            end
        end
        else
        begin
            case (phase_reg)
                PH_ACK_DATA:
                begin
                    if (!cmd.is_ack)
                    begin
                        r0.done_res = 1'b1;
                        r0.status   = ST_BUSY;
                        r0.last     = 1'b1;
                        n           = 2'd1;
                        phase_next  = PH_IDLE;
                    end
                    else
                    begin
                        chunk_next = '0;
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    r0.data_valid  = 1'b1;
                    r0.data_offset = 24'(off_reg);
                    r0.data_byte   = cmd.rx_byte;
                    run_next       = run_reg + 32'(cmd.rx_byte);
                    off_next       = off_inc;
                    chunk_next     = chunk_inc;
                    if (off_inc_ext >= len_now)
                    begin
                        phase_next = PH_END;
                        r0.last    = 1'b1;
                        n          = 2'd1;
                    end
                    else if (chunk_inc >= CCW'(CHUNK_BYTES))
                    begin
                        phase_next  = PH_ACK_DATA;
                        r1.tx_valid = 1'b1;
                        r1.tx_byte  = sync_code;
                        r1.last     = 1'b1;
                        n           = 2'd2;
                    end
                    else
                    begin
                        r0.last = 1'b1;
                        n       = 2'd1;
                    end
                end
                PH_END:
                begin
                    if (!cmd.is_end)
                    begin
                        r0.done_res = 1'b1;
                        r0.status   = ST_NO_END;
                        r0.last     = 1'b1;
                        n           = 2'd1;
                        phase_next  = PH_IDLE;
                    end
                    else
                    begin
                        r0.tx_valid = 1'b1;
                        r0.tx_byte  = check_code;
                        r1.tx_valid = 1'b1;
                        r1.tx_byte  = sync_code;
                        r1.last     = 1'b1;
                        n           = 2'd2;
                        phase_next  = PH_ACK_SUM;
                    end
                end
                PH_ACK_SUM:
                begin
                    if (!cmd.is_ack)
                    begin
                        r0.done_res = 1'b1;
                        r0.status   = ST_BUSY;
                        r0.last     = 1'b1;
                        n           = 2'd1;
                        phase_next  = PH_IDLE;
                    end
                    else
                    begin
                        rsum_next  = '0;
                        scnt_next  = '0;
                        phase_next = PH_SUM;
                    end
                end
                PH_SUM:
                begin
                    rsum_next = rsum_upd;
                    scnt_next = scnt_reg + 1'b1;
                    if (scnt_reg == 2'd3)
                    begin
                        r0.done_res = 1'b1;
                        r0.status   = (rsum_upd == run_reg) ? ST_OK : ST_BAD_SUM;
                        r0.last     = 1'b1;
                        n           = 2'd1;
                        phase_next  = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        res_push.cnt = cmd_pop ? n : 2'd0;
        res_push.r0  = r0;
        res_push.r1  = r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            chunk_reg <= '0;
            off_reg   <= '0;
            run_reg   <= '0;
            rsum_reg  <= '0;
            scnt_reg  <= '0;
        end
        else if (cmd_pop)
        begin
            phase_reg <= phase_next;
            chunk_reg <= chunk_next;
            off_reg   <= off_next;
            run_reg   <= run_next;
            rsum_reg  <= rsum_next;
            scnt_reg  <= scnt_next;
        end
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && r0.done_res) |=> (phase_reg == PH_IDLE))
        else $error("finished transfer did not return to idle");

    a_chunk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (chunk_reg < CCW'(CHUNK_BYTES)))
        else $error("chunk count ran past chunk size");

endmodule

@@ src/cfrp_resq.sv @@
// Result queue: up to two writes per cycle from the engine, one read.
// Depends on cfrp_pkg.
module cfrp_resq
    import cfrp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  res_push_t         res_push,
    output logic [RQ_PTR_W:0] res_free,
    output logic              empty,
    input  logic              pop,
    output res_t              head
);

    res_t                mem_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] wp_reg, wp_next;
    logic [RQ_PTR_W-1:0] rp_reg, rp_next;
    logic [RQ_PTR_W:0]   cnt_reg, cnt_next;
    logic [RQ_PTR_W-1:0] wp_plus1;
    logic                pop_ok;

    assign empty    = (cnt_reg == '0);
    assign pop_ok   = pop && !empty;
    assign res_free = (RQ_PTR_W+1)'(RQ_DEPTH) - cnt_reg;
    assign head     = mem_reg[rp_reg];
    assign wp_plus1 = wp_reg + 1'b1;

    always_comb
    begin
        wp_next  = wp_reg + RQ_PTR_W'(res_push.cnt);
        rp_next  = pop_ok ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (RQ_PTR_W+1)'(res_push.cnt) - (RQ_PTR_W+1)'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push.cnt != 2'd0)
        begin
            mem_reg[wp_reg] <= res_push.r0;
        end
        if (res_push.cnt == 2'd2)
        begin
            mem_reg[wp_plus1] <= res_push.r1;
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (RQ_PTR_W+1)'(res_push.cnt) <= res_free)
        else $error("result queue overrun");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_ok && (res_push.cnt == 2'd0)) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("result queue pop lost");

endmodule

@@ src/chunked_file_receive_protocol.sv @@
// Top level of the chunked file receiver: configuration registers and glue.
// Depends on cfrp_pkg, cfrp_cmdq, cfrp_engine, cfrp_resq.
//
//  channel   handshake              payload
//  -------   ---------------------  -----------------------------------------
//  input     push / full            mode, rx_byte
//  result    empty / pop            tx_valid, tx_byte, data_valid, data_offset,
//                                   data_byte, done_res, status, last
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per clock sustained while the result queue has two free slots; the engine handles each item in one step.
// An item is registered in the input queue, and its results are registered in the result queue before the ports.
// The engine steps only when the 4-entry result queue has two free slots.
// Input queue holds 4 items; full rises when it does. cfg_ready is always high.
// rst_n clears all control state and loads the register reset values.
module chunked_file_receive_protocol
    import cfrp_pkg::*;
#(
    parameter int CHUNK_BYTES = 16,
    parameter int LENGTH_BITS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  mode,
    input  logic [7:0]            rx_byte,
    output logic                  empty,
    input  logic                  pop,
    output logic                  tx_valid,
    output logic [7:0]            tx_byte,
    output logic                  data_valid,
    output logic [23:0]           data_offset,
    output logic [7:0]            data_byte,
    output logic                  done_res,
    output logic [1:0]            status,
    output logic                  last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [23:0]       len_reg;
    logic [7:0]        sync_reg;
    logic [7:0]        ack_reg;
    logic [7:0]        end_reg;
    logic [7:0]        check_reg;
    logic              msb_reg;
    logic              cfg_wr;
    logic              cmd_valid;
    cmd_t              cmd;
    logic              cmd_pop;
    logic [RQ_PTR_W:0] res_free;
    res_push_t         res_push;
    res_t              head;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= RST_TRANSFER_LENGTH;
            sync_reg  <= RST_SYNC_CODE;
            ack_reg   <= RST_ACK_CODE;
            end_reg   <= RST_END_CODE;
            check_reg <= RST_CHECK_CODE;
            msb_reg   <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                CFG_TRANSFER_LENGTH: len_reg   <= cfg_data[23:0];
                CFG_SYNC_CODE:       sync_reg  <= cfg_data[7:0];
                CFG_ACK_CODE:        ack_reg   <= cfg_data[7:0];
                CFG_END_CODE:        end_reg   <= cfg_data[7:0];
                CFG_CHECK_CODE:      check_reg <= cfg_data[7:0];
                CFG_SUM_MSB_FIRST:   msb_reg   <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    cfrp_cmdq u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .mode      (mode),
        .rx_byte   (rx_byte),
        .ack_code  (ack_reg),
        .end_code  (end_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    cfrp_engine #(
        .CHUNK_BYTES (CHUNK_BYTES),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_pop         (cmd_pop),
        .res_free        (res_free),
        .res_push        (res_push),
        .transfer_length (len_reg),
        .sync_code       (sync_reg),
        .check_code      (check_reg),
        .sum_msb_first   (msb_reg)
    );

    cfrp_resq u_resq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_free (res_free),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

    assign tx_valid    = head.tx_valid;
    assign tx_byte     = head.tx_byte;
    assign data_valid  = head.data_valid;
    assign data_offset = head.data_offset;
    assign data_byte   = head.data_byte;
    assign done_res    = head.done_res;
    assign status      = head.status;
    assign last        = head.last;

endmodule

@@ tb/tb_chunked_file_receive_protocol.sv @@
// Self-checking testbench for the chunked file receiver: directed and random uploads,
// a cycle-free model of the receive protocol, random idling on both queue sides.
// Depends on cfrp_pkg and chunked_file_receive_protocol.
module tb_chunked_file_receive_protocol;
    import cfrp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHUNK_SIZE    = 16;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 1200;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_BYTE  = 1'b1;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            push      = 1'b0;
    logic            full;
    logic            mode      = MODE_START;
    logic [7:0]      rx_byte   = 8'h00;
    logic            empty;
    logic            pop       = 1'b0;
    logic            tx_valid;
    logic [7:0]      tx_byte;
    logic            data_valid;
    logic [23:0]     data_offset;
    logic [7:0]      data_byte;
    logic            done_res;
    logic [1:0]      status;
    logic            last;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    cfg_idx_t        cfg_index = CFG_TRANSFER_LENGTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // register copies
    logic [23:0] cfg_length;
    logic [7:0]  cfg_sync;
    logic [7:0]  cfg_ack;
    logic [7:0]  cfg_end;
    logic [7:0]  cfg_check;
    logic        cfg_msb_first;

    // protocol state
    phase_t      ph;
    int          chunk_fill;
    logic [23:0] file_off;
    logic [31:0] byte_sum;
    logic [31:0] got_sum;
    logic [2:0]  sum_bytes;

    res_t rx_results_due[$];

    int mismatches   = 0;
    int items_sent   = 0;
    int send_idle_pct = 0;
    int take_idle_pct = 0;
    int hold_request = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    chunked_file_receive_protocol u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .mode        (mode),
        .rx_byte     (rx_byte),
        .empty       (empty),
        .pop         (pop),
        .tx_valid    (tx_valid),
        .tx_byte     (tx_byte),
        .data_valid  (data_valid),
        .data_offset (data_offset),
        .data_byte   (data_byte),
        .done_res    (done_res),
        .status      (status),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #10 clk = ~clk;

    task automatic reset_model();
        cfg_length    = RST_TRANSFER_LENGTH;
        cfg_sync      = RST_SYNC_CODE;
        cfg_ack       = RST_ACK_CODE;
        cfg_end       = RST_END_CODE;
        cfg_check     = RST_CHECK_CODE;
        cfg_msb_first = 1'b0;
        ph            = PH_IDLE;
        chunk_fill    = 0;
        file_off      = '0;
        byte_sum      = '0;
        got_sum       = '0;
        sum_bytes     = '0;
    endtask

    function automatic void report_done(logic [1:0] st);
        res_t r;
        r          = '0;
        r.done_res = 1'b1;
        r.status   = st;
        r.last     = 1'b1;
        rx_results_due.push_back(r);
        ph = PH_IDLE;
    endfunction

    function automatic res_t tx_result(logic [7:0] code, logic is_last);
        res_t r;
        r          = '0;
        r.tx_valid = 1'b1;
        r.tx_byte  = code;
        r.last     = is_last;
        return r;
    endfunction

    // advance the protocol by one accepted item and queue what it emits
    function automatic void step_transfer(logic m, logic [7:0] b);
        res_t r;
        r = '0;
        if (m == MODE_START)
        begin
            chunk_fill = 0;
            file_off   = '0;
            byte_sum   = '0;
            got_sum    = '0;
            sum_bytes  = '0;
            if (cfg_length == '0)
            begin
                ph = PH_END;
            end
            else
            begin
                ph = PH_ACK_DATA;
                rx_results_due.push_back(tx_result(cfg_sync, 1'b1));
            end
            return;
        end
        case (ph)
            PH_ACK_DATA:
            begin
                if (b != cfg_ack)
                    report_done(ST_BUSY);
                else
                begin
                    chunk_fill = 0;
                    ph = PH_DATA;
                end
            end
            PH_DATA:
            begin
                r.data_valid  = 1'b1;
                r.data_offset = file_off;
                r.data_byte   = b;
                byte_sum      = byte_sum + 32'(b);
                file_off      = file_off + 24'd1;
                chunk_fill++;
                if (file_off >= cfg_length)
                begin
                    ph = PH_END;
                    r.last = 1'b1;
                    rx_results_due.push_back(r);
                end
                else if (chunk_fill >= CHUNK_SIZE)
                begin
                    ph = PH_ACK_DATA;
                    rx_results_due.push_back(r);
                    rx_results_due.push_back(tx_result(cfg_sync, 1'b1));
                end
                else
                begin
                    r.last = 1'b1;
                    rx_results_due.push_back(r);
                end
            end
            PH_END:
            begin
                if (b != cfg_end)
                    report_done(ST_NO_END);
                else
                begin
                    rx_results_due.push_back(tx_result(cfg_check, 1'b0));
                    rx_results_due.push_back(tx_result(cfg_sync, 1'b1));
                    ph = PH_ACK_SUM;
                end
            end
            PH_ACK_SUM:
            begin
                if (b != cfg_ack)
                    report_done(ST_BUSY);
                else
                begin
                    got_sum   = '0;
                    sum_bytes = '0;
                    ph = PH_SUM;
                end
            end
            PH_SUM:
            begin
                // OR-in keeps bytes already placed if the order flag flips mid-sum
                if (cfg_msb_first)
                    got_sum = {got_sum[23:0], b};
                else
                    got_sum = got_sum | (32'(b) << (8 * int'(sum_bytes[1:0])));
                sum_bytes = sum_bytes + 3'd1;
                if (sum_bytes >= 3'd4)
                    report_done((got_sum == byte_sum) ? ST_OK : ST_BAD_SUM);
            end
            default:
            begin
                ph = PH_IDLE;
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic check_result();
        res_t want;
        if (rx_results_due.size() == 0)
        begin
            $error("unexpected result: tx_valid %0b tx_byte 0x%0h data_valid %0b done_res %0b",
                   tx_valid, tx_byte, data_valid, done_res);
            mismatches++;
            return;
        end
        want = rx_results_due.pop_front();
        check_field("tx_valid", 32'(want.tx_valid), 32'(tx_valid));
        check_field("tx_byte", 32'(want.tx_byte), 32'(tx_byte));
        check_field("data_valid", 32'(want.data_valid), 32'(data_valid));
        check_field("data_offset", 32'(want.data_offset), 32'(data_offset));
        check_field("data_byte", 32'(want.data_byte), 32'(data_byte));
        check_field("done_res", 32'(want.done_res), 32'(done_res));
        check_field("status", 32'(want.status), 32'(status));
        check_field("last", 32'(want.last), 32'(last));
    endtask

    // result side: checks each popped transaction, random stalls, long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
                check_result();
            if (hold_request != hold_seen)
            begin
                hold_seen = hold_request;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(99) >= take_idle_pct);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_chunked_file_receive_protocol failed");
        $finish;
    end

    task automatic send_item(input logic m, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        mode    <= m;
        rx_byte <= b;
        @(posedge clk);
        while (full) @(posedge clk);
        // bytes dropped while idle are not counted
        if (m == MODE_START || ph != PH_IDLE)
            items_sent++;
        step_transfer(m, b);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_TRANSFER_LENGTH: cfg_length    = val;
            CFG_SYNC_CODE:       cfg_sync      = val[7:0];
            CFG_ACK_CODE:        cfg_ack       = val[7:0];
            CFG_END_CODE:        cfg_end       = val[7:0];
            CFG_CHECK_CODE:      cfg_check     = val[7:0];
            CFG_SUM_MSB_FIRST:   cfg_msb_first = val[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // stop sending, wait for every queued result, then let the input queue empty out
    task automatic drain();
        push <= 1'b0;
        while (rx_results_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one upload; replies are mostly correct so that the later phases are reached
    task automatic run_transfer(input logic [23:0] len, input int budget);
        int         n;
        logic       m;
        logic [7:0] b;
        drain();
        write_reg(CFG_TRANSFER_LENGTH, len);
        send_item(MODE_START, 8'($urandom));
        n = 1;
        while (ph != PH_IDLE && n < budget)
        begin
            m = MODE_BYTE;
            b = 8'($urandom);
            case (ph)
                PH_ACK_DATA, PH_ACK_SUM:
                    if ($urandom_range(99) < 92) b = cfg_ack;
                PH_END:
                    if ($urandom_range(99) < 92) b = cfg_end;
                PH_SUM:
                    if ($urandom_range(99) < 85)
                    begin
                        if (cfg_msb_first)
                            b = 8'(byte_sum >> (8 * (3 - int'(sum_bytes))));
                        else
                            b = 8'(byte_sum >> (8 * int'(sum_bytes)));
                    end
                default: ;
            endcase
            if ($urandom_range(199) == 0)
                m = MODE_START;
            send_item(m, b);
            n++;
        end
    endtask

    task automatic test_defaults_and_empty();
        send_item(MODE_BYTE, 8'hA5);
        send_item(MODE_START, 8'h00);
        send_item(MODE_BYTE, 8'hFF);
        send_item(MODE_START, 8'hFF);
        send_item(MODE_BYTE, cfg_end);
        send_item(MODE_BYTE, cfg_ack);
        repeat (4) send_item(MODE_BYTE, 8'h00);
    endtask

    task automatic test_code_extremes();
        drain();
        write_reg(CFG_SYNC_CODE, 24'h000000);
        write_reg(CFG_ACK_CODE, 24'hFFFFFF);
        write_reg(CFG_END_CODE, 24'hFFFF00);
        write_reg(CFG_CHECK_CODE, 24'h0000FF);
        write_reg(CFG_SUM_MSB_FIRST, 24'h000001);
        write_reg(CFG_TRANSFER_LENGTH, 24'd1);
        send_item(MODE_START, 8'h00);
        send_item(MODE_BYTE, 8'h00);
        send_item(MODE_START, 8'h00);
        send_item(MODE_BYTE, cfg_ack);
        send_item(MODE_BYTE, 8'h80);
        send_item(MODE_BYTE, cfg_end);
        send_item(MODE_BYTE, cfg_ack);
        send_item(MODE_BYTE, 8'h00);
        send_item(MODE_BYTE, 8'h00);
        send_item(MODE_BYTE, 8'h00);
        send_item(MODE_BYTE, 8'h80);
    endtask

    task automatic test_length_lowered();
        drain();
        write_reg(CFG_TRANSFER_LENGTH, 24'd40);
        send_item(MODE_START, 8'h5A);
        send_item(MODE_BYTE, cfg_ack);
        send_item(MODE_BYTE, 8'h11);
        drain();
        write_reg(CFG_TRANSFER_LENGTH, 24'd1);
        send_item(MODE_BYTE, 8'h22);
        // start in the end phase abandons the transfer
        send_item(MODE_START, 8'h33);
    endtask

    task automatic test_result_backpressure();
        // empty out first so the hold-off lands on the upload below
        drain();
        send_idle_pct = 0;
        hold_request <= hold_request + 1;
        run_transfer(24'd20, 100);
    endtask

    task automatic shuffle_codes();
        if ($urandom_range(2) == 0) write_reg(CFG_SYNC_CODE, 24'($urandom));
        if ($urandom_range(2) == 0) write_reg(CFG_ACK_CODE, 24'($urandom));
        if ($urandom_range(2) == 0) write_reg(CFG_END_CODE, 24'($urandom));
        if ($urandom_range(2) == 0) write_reg(CFG_CHECK_CODE, 24'($urandom));
        if ($urandom_range(2) == 0) write_reg(CFG_SUM_MSB_FIRST, 24'($urandom));
    endtask

    task automatic test_random_transfers();
        int          start_count;
        int          done_count;
        int          pick;
        logic [23:0] len;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            done_count = items_sent - start_count;
            if (done_count < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 22;
                take_idle_pct = 81;
            end
            else if (done_count < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 81;
                take_idle_pct = 22;
            end
            else
            begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end
            drain();
            shuffle_codes();
            pick = $urandom_range(99);
            if (pick < 8)
                len = '0;
            else if (pick < 75)
                len = 24'($urandom_range(40, 1));
            else if (pick < 95)
                len = 24'($urandom_range(100, 41));
            else if (pick < 97)
                len = 24'hFFFFFF;
            else
                len = 24'($urandom_range(24'hFFFFFE, 24'h800000));
            run_transfer(len, (len > 24'd100) ? 40 : 400);
            if (ph == PH_IDLE && $urandom_range(3) == 0)
                send_item(MODE_BYTE, 8'($urandom));
        end
    endtask

    initial
    begin
        reset_model();
        send_idle_pct = 22;
        take_idle_pct = 81;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults_and_empty();
        test_code_extremes();
        test_length_lowered();
        test_result_backpressure();
        test_random_transfers();
        drain();
        if (mismatches == 0)
            $display("tb_chunked_file_receive_protocol passed");
        else
            $display("tb_chunked_file_receive_protocol failed");
        $finish;
    end

endmodule
